// File: hw/rtl/fsp_pkg.sv
package fsp_pkg;

  localparam int WH_W      = 16;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 6;
  localparam int LVL_W     = 7;
  localparam int ROW_SHIFT = 3;

  localparam int DEF_MAX_HALF_HEIGHT = 64;
  localparam int DEF_MAX_COLUMNS     = 1024;

  localparam logic [LVL_W-1:0] HALF_HEIGHT_RESET = LVL_W'(64);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SHRINK = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SHOW   = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;  // latch the incoming request
    logic shrink;  // open one more row below the open level
    logic read;    // read the row store and load the span registers
  } cmd_t;

  typedef struct packed {
    logic shrink_in;    // incoming wall is below the open level
    logic emit_in;      // incoming request closes at least one span
    logic shrink_done;  // this shrink step reaches the wall row
    logic more;         // spans remain for the current request
  } status_t;

endpackage

// File: hw/rtl/fsp_ctrl.sv
module fsp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_stall,
  input  fsp_pkg::status_t status,
  output fsp_pkg::cmd_t    cmd,
  output logic            in_stall,
  output logic            out_valid
);
  import fsp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.shrink_in) begin
            state_next = ST_SHRINK;
          end else if (status.emit_in) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SHRINK: begin
        cmd.shrink = 1'b1;
        if (status.shrink_done) begin
          // a flush on the last column may follow the shrink
          state_next = status.more ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall) begin
          state_next = status.more ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_SHOW);

endmodule

// File: hw/rtl/fsp_datapath.sv
module fsp_datapath #(
  parameter int MAX_HALF_HEIGHT = fsp_pkg::DEF_MAX_HALF_HEIGHT,
  parameter int MAX_COLUMNS     = fsp_pkg::DEF_MAX_COLUMNS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [fsp_pkg::LVL_W-1:0] cfg_wdata,
  input  logic [fsp_pkg::WH_W-1:0]  wall_height,
  input  logic [fsp_pkg::COL_W-1:0] column,
  input  logic                      last_column,
  input  fsp_pkg::cmd_t             cmd,
  output fsp_pkg::status_t          status,
  output logic [fsp_pkg::COL_W-1:0] span_first_column,
  output logic [fsp_pkg::COL_W-1:0] span_last_column,
  output logic [fsp_pkg::ROW_W-1:0] span_row,
  output logic                      last_of_run
);
  import fsp_pkg::*;

  localparam int ADDR_W = (MAX_HALF_HEIGHT > 1) ? $clog2(MAX_HALF_HEIGHT) : 1;
  localparam logic [LVL_W-1:0] MAX_LVL  = LVL_W'(MAX_HALF_HEIGHT);
  localparam logic [COL_W-1:0] WRAP_COL = COL_W'(MAX_COLUMNS - 1);
  localparam int HROW_W = WH_W - ROW_SHIFT;

  logic [LVL_W-1:0] half_height;
  logic [LVL_W-1:0] open_level;
  logic [LVL_W-1:0] open_level_next;
  logic [LVL_W-1:0] cap;
  logic [LVL_W-1:0] stop;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] prev_col;

  logic [COL_W-1:0] row_start [MAX_HALF_HEIGHT];

  logic [LVL_W-1:0]  hh;
  logic [LVL_W-1:0]  hh_cfg;
  logic [HROW_W-1:0] h_full;
  logic [LVL_W-1:0]  h_sat;
  logic [LVL_W-1:0]  cap_in;
  logic [LVL_W-1:0]  stop_in;
  logic [LVL_W-1:0]  level_dec;
  logic [LVL_W-1:0]  level_inc;

  assign hh     = (half_height > MAX_LVL) ? MAX_LVL : half_height;
  assign hh_cfg = (cfg_wdata > MAX_LVL) ? MAX_LVL : cfg_wdata;

  // rows above 127 behave the same as 127: the open level never exceeds MAX_HALF_HEIGHT
  assign h_full = wall_height[WH_W-1:ROW_SHIFT];
  assign h_sat  = (|h_full[HROW_W-1:LVL_W]) ? {LVL_W{1'b1}} : h_full[LVL_W-1:0];

  // rows below cap close at the previous column, the rest at this column
  assign cap_in  = (h_sat > open_level) ? ((h_sat < hh) ? h_sat : hh) : h_sat;
  assign stop_in = last_column ? hh : cap_in;

  assign level_dec = open_level - LVL_W'(1);
  assign level_inc = open_level + LVL_W'(1);

  assign status.shrink_in   = (h_sat < open_level);
  assign status.emit_in     = (stop_in > open_level);
  assign status.shrink_done = (level_dec == cap);
  assign status.more        = cmd.shrink ? (stop > cap) : (stop > open_level);

  always_comb begin
    open_level_next = open_level;
    if (cfg_we) begin
      open_level_next = hh_cfg;
    end else if (cmd.shrink) begin
      open_level_next = level_dec;
    end else if (cmd.read) begin
      open_level_next = level_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_height <= HALF_HEIGHT_RESET;
      open_level  <= (HALF_HEIGHT_RESET > MAX_LVL) ? MAX_LVL : HALF_HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        half_height <= cfg_wdata;
      end
      open_level <= open_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col      <= column;
      prev_col <= (column == '0) ? WRAP_COL : column - COL_W'(1);
      cap      <= cap_in;
      stop     <= stop_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shrink) begin
      row_start[level_dec[ADDR_W-1:0]] <= col;
    end
    if (cmd.read) begin
      span_first_column <= row_start[open_level[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      span_last_column <= (open_level < cap) ? prev_col : col;
      span_row         <= open_level[ROW_W-1:0];
      last_of_run      <= (level_inc == stop);
    end
  end

endmodule

// File: hw/rtl/floor_span_extractor_core.sv
// Floor span extractor.
// Input channel (in_valid / in_stall): one screen column per request, with
// its raw wall height, its column index and a flag on the last column.
// Output channel (out_valid / out_stall): floor spans, each with first and
// last column and row; last_of_run marks the final span of a request.
// cfg_we / cfg_wdata write the half height (rows in use); this also starts
// a new frame. Write only while the block is idle.
// Sequence: a request is taken in the idle state. Each row opened by a falling
// wall then costs a shrink step (one row store write per cycle). Each span
// costs a row store read, then a show state that holds until out_stall is
// low; the first span is shown after the rows it opens and that read.
// One request is in flight at a time; in_stall stays high until its last
// span has been taken. A stalled span holds on the outputs.
// Reset (rst, synchronous): half height 64, open level 64 (capped at
// MAX_HALF_HEIGHT), idle. The row store is not cleared; rows are written before they are read.
module floor_span_extractor_core #(
  parameter int MAX_HALF_HEIGHT = fsp_pkg::DEF_MAX_HALF_HEIGHT,
  parameter int MAX_COLUMNS     = fsp_pkg::DEF_MAX_COLUMNS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [fsp_pkg::LVL_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [fsp_pkg::WH_W-1:0]  wall_height,
  input  logic [fsp_pkg::COL_W-1:0] column,
  input  logic                      last_column,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fsp_pkg::COL_W-1:0] span_first_column,
  output logic [fsp_pkg::COL_W-1:0] span_last_column,
  output logic [fsp_pkg::ROW_W-1:0] span_row,
  output logic                      last_of_run
);
  import fsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  fsp_datapath #(
    .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT),
    .MAX_COLUMNS     (MAX_COLUMNS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .wall_height       (wall_height),
    .column            (column),
    .last_column       (last_column),
    .cmd               (cmd),
    .status            (status),
    .span_first_column (span_first_column),
    .span_last_column  (span_last_column),
    .span_row          (span_row),
    .last_of_run       (last_of_run)
  );

endmodule

// File: hw/rtl/fsp_checker.sv
module fsp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [fsp_pkg::COL_W-1:0] span_first_column,
  input logic [fsp_pkg::COL_W-1:0] span_last_column,
  input logic [fsp_pkg::ROW_W-1:0] span_row,
  input logic                      last_of_run
);
  import fsp_pkg::*;

  // no new request while a span is on show
  a_busy_while_showing: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> in_stall
  ) else $error("request taken while a span is pending");

  // a run that is not finished keeps the input closed
  a_run_holds_input: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |=> in_stall
  ) else $error("input opened in the middle of a run");

  // spans of one run come in rising row order, one row apart
  a_rows_rise: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |=> ##1
      (out_valid && (span_row == ROW_W'($past(span_row, 2) + ROW_W'(1))))
  ) else $error("next span of the run is not the next row");

  a_stall_holds: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(span_first_column) && $stable(span_last_column)
       && $stable(span_row) && $stable(last_of_run))
  ) else $error("stalled span changed");

endmodule

bind floor_span_extractor_core fsp_checker u_fsp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .span_first_column (span_first_column),
  .span_last_column  (span_last_column),
  .span_row          (span_row),
  .last_of_run       (last_of_run)
);
